### hw/rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the transcoder RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/utu_pkg.sv
// -----------------------------------------------------------------------------
// utu_pkg
// Types and constants for the UTF-8 to UTF-16/UTF-32 transcoder.
// -----------------------------------------------------------------------------
package utu_pkg;

    localparam int DATA_W  = 8;
    localparam int CV_W    = 21;
    localparam int ST_W    = 3;
    localparam int PV_W    = 15;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [DATA_W-1:0] ASCII_END = 8'h80;
    localparam logic [DATA_W-1:0] LEAD2_MIN = 8'hC2;
    localparam logic [DATA_W-1:0] LEAD3_MIN = 8'hE0;
    localparam logic [DATA_W-1:0] LEAD4_MIN = 8'hF0;
    localparam logic [DATA_W-1:0] LEAD_END  = 8'hF8;

    localparam logic [CV_W-1:0] SUPP_BASE = 21'h010000;
    localparam logic [CV_W-1:0] HI_SURR   = 21'h00D800;
    localparam logic [CV_W-1:0] LO_SURR   = 21'h00DC00;
    localparam logic [CV_W-1:0] MAX_CP    = 21'h10FFFF;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEAD  = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_CONT  = 3'd2;
    localparam logic [ST_W-1:0] ST_OVERLONG  = 3'd3;
    localparam logic [ST_W-1:0] ST_TRUNCATED = 3'd4;
    localparam logic [ST_W-1:0] ST_RANGE     = 3'd5;

    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    localparam logic REG_EMIT_UTF32 = 1'b0;

    typedef struct packed {
        logic [CV_W-1:0] code_value;
        logic [ST_W-1:0] status;
        logic            last_of_run;
        logic            text_done;
    } result_t;

    typedef struct packed {
        logic    push;
        logic    pair;
        result_t res0;
        result_t res1;
    } dec_push_t;

endpackage

### hw/rtl/utu_ifs.sv
// -----------------------------------------------------------------------------
// utu_ifs
// Valid/ready channel interfaces for byte input and result output.
// -----------------------------------------------------------------------------
interface utu_in_if import utu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface utu_out_if import utu_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CV_W-1:0] code_value;
    logic [ST_W-1:0] status;
    logic            last_of_run;
    logic            text_done;

    modport source (output valid, output code_value, output status, output last_of_run,
                    output text_done, input ready);
    modport sink   (input valid, input code_value, input status, input last_of_run,
                    input text_done, output ready);
endinterface

### hw/rtl/utu_apb_regs.sv
// -----------------------------------------------------------------------------
// utu_apb_regs
// APB configuration register file: holds the emit_utf32 mode bit.
// -----------------------------------------------------------------------------
module utu_apb_regs import utu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic               emit_utf32
);

    logic emit_utf32_reg;
    logic emit_utf32_next;
    logic sel_emit;

    assign pready   = 1'b1;
    assign sel_emit = (paddr[PADDR_W-1:2] == REG_EMIT_UTF32);

    always_comb
    begin
        emit_utf32_next = emit_utf32_reg;
        if (psel && penable && pwrite && sel_emit)
        begin
            emit_utf32_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_utf32_reg <= 1'b0;
        end
        else
        begin
            emit_utf32_reg <= emit_utf32_next;
        end
    end

    assign prdata     = sel_emit ? {{(PDATA_W-1){1'b0}}, emit_utf32_reg} : '0;
    assign emit_utf32 = emit_utf32_reg;

endmodule

### hw/rtl/utu_decoder.sv
// -----------------------------------------------------------------------------
// utu_decoder
// Input register, UTF-8 sequence state and single-pass decode into up to two
// result items per byte.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module utu_decoder import utu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      emit_utf32,
    utu_in_if.sink    text_in,
    input  logic      out_free,
    output dec_push_t dec_push
);

    logic              in_valid_reg;
    logic [DATA_W-1:0] in_byte_reg;
    logic              in_eot_reg;

    logic [1:0]      bytes_left_reg,  bytes_left_next;
    logic [2:0]      seq_length_reg,  seq_length_next;
    logic [PV_W-1:0] partial_reg,     partial_next;
    logic            lead_zero_reg,   lead_zero_next;
    logic            await_2nd_reg,   await_2nd_next;

    logic            cp_done;
    logic [CV_W-1:0] cp;
    logic [CV_W-1:0] cp_off;
    logic            err;
    logic [ST_W-1:0] err_code;
    logic            overlong;
    logic            trunc;
    logic [1:0]      n_res;
    result_t         res0;
    result_t         res1;
    logic            take;
    logic            in_accept;

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        seq_length_next = seq_length_reg;
        partial_next    = partial_reg;
        lead_zero_next  = lead_zero_reg;
        await_2nd_next  = await_2nd_reg;
        cp              = {{(CV_W-DATA_W){1'b0}}, in_byte_reg};
        cp_done         = 1'b0;
        err             = 1'b0;
        err_code        = ST_OK;
        overlong        = 1'b0;

        if (bytes_left_reg == 2'd0)
        begin
            if (in_byte_reg < ASCII_END)
            begin
                cp_done = 1'b1;
            end
            else if (in_byte_reg >= LEAD2_MIN && in_byte_reg < LEAD3_MIN)
            begin
                seq_length_next = SEQ_TWO;
                bytes_left_next = 2'd1;
                partial_next    = {{(PV_W-5){1'b0}}, in_byte_reg[4:0]};
            end
            else if (in_byte_reg >= LEAD3_MIN && in_byte_reg < LEAD4_MIN)
            begin
                seq_length_next = SEQ_THREE;
                bytes_left_next = 2'd2;
                partial_next    = {{(PV_W-4){1'b0}}, in_byte_reg[3:0]};
                lead_zero_next  = (in_byte_reg[3:0] == 4'd0);
                await_2nd_next  = 1'b1;
            end
            else if (in_byte_reg >= LEAD4_MIN && in_byte_reg < LEAD_END)
            begin
                seq_length_next = SEQ_FOUR;
                bytes_left_next = 2'd3;
                partial_next    = {{(PV_W-3){1'b0}}, in_byte_reg[2:0]};
                lead_zero_next  = (in_byte_reg[2:0] == 3'd0);
                await_2nd_next  = 1'b1;
            end
            else
            begin
                err      = 1'b1;
                err_code = ST_BAD_LEAD;
            end
        end
        else if (in_byte_reg[7:6] != 2'b10)
        begin
            err             = 1'b1;
            err_code        = ST_BAD_CONT;
            bytes_left_next = 2'd0;
            seq_length_next = SEQ_NONE;
            partial_next    = '0;
            lead_zero_next  = 1'b0;
            await_2nd_next  = 1'b0;
        end
        else
        begin
            overlong = await_2nd_reg && lead_zero_reg &&
                       ((seq_length_reg == SEQ_THREE && !in_byte_reg[5]) ||
                        (seq_length_reg == SEQ_FOUR && in_byte_reg[5:4] == 2'b00));
            await_2nd_next = 1'b0;
            if (overlong)
            begin
                err             = 1'b1;
                err_code        = ST_OVERLONG;
                bytes_left_next = 2'd0;
                seq_length_next = SEQ_NONE;
                partial_next    = '0;
                lead_zero_next  = 1'b0;
            end
            else
            begin
                partial_next    = {partial_reg[PV_W-7:0], in_byte_reg[5:0]};
                bytes_left_next = bytes_left_reg - 2'd1;
                cp              = {partial_reg, in_byte_reg[5:0]};
                if (bytes_left_reg == 2'd1)
                begin
                    cp_done         = 1'b1;
                    bytes_left_next = 2'd0;
                    seq_length_next = SEQ_NONE;
                    partial_next    = '0;
                    lead_zero_next  = 1'b0;
                end
            end
        end

        trunc = in_eot_reg && (bytes_left_next != 2'd0);
        if (in_eot_reg)
        begin
            bytes_left_next = 2'd0;
            seq_length_next = SEQ_NONE;
            partial_next    = '0;
            lead_zero_next  = 1'b0;
            await_2nd_next  = 1'b0;
        end
    end

    assign cp_off = cp - SUPP_BASE;

    always_comb
    begin
        res0  = '0;
        res1  = '0;
        n_res = 2'd0;
        if (err)
        begin
            res0.status = err_code;
            n_res       = 2'd1;
        end
        else if (cp_done)
        begin
            if (emit_utf32 || cp < SUPP_BASE)
            begin
                res0.code_value = cp;
                n_res           = 2'd1;
            end
            else if (cp > MAX_CP)
            begin
                res0.status = ST_RANGE;
                n_res       = 2'd1;
            end
            else
            begin
                res0.code_value = HI_SURR + {{(CV_W-11){1'b0}}, cp_off[20:10]};
                res1.code_value = LO_SURR + {{(CV_W-10){1'b0}}, cp[9:0]};
                n_res           = 2'd2;
            end
        end
        else if (trunc)
        begin
            res0.status = ST_TRUNCATED;
            n_res       = 2'd1;
        end

        if (n_res == 2'd2)
        begin
            res1.last_of_run = 1'b1;
            res1.text_done   = in_eot_reg;
        end
        else
        begin
            res0.last_of_run = 1'b1;
            res0.text_done   = in_eot_reg;
        end
    end

    assign take          = in_valid_reg && (out_free || n_res == 2'd0);
    assign text_in.ready = !in_valid_reg || take;
    assign in_accept     = text_in.valid && text_in.ready;

    assign dec_push.push = take && (n_res != 2'd0);
    assign dec_push.pair = (n_res == 2'd2);
    assign dec_push.res0 = res0;
    assign dec_push.res1 = res1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            bytes_left_reg <= 2'd0;
            seq_length_reg <= SEQ_NONE;
            partial_reg    <= '0;
            lead_zero_reg  <= 1'b0;
            await_2nd_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                in_valid_reg <= 1'b0;
            end
            if (take)
            begin
                bytes_left_reg <= bytes_left_next;
                seq_length_reg <= seq_length_next;
                partial_reg    <= partial_next;
                lead_zero_reg  <= lead_zero_next;
                await_2nd_reg  <= await_2nd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= text_in.data_byte;
            in_eot_reg  <= text_in.end_of_text;
        end
    end

    `ASSERT_IMPL(a_idle_clean, clk, rst_n, bytes_left_reg == 2'd0,
        seq_length_reg == SEQ_NONE && !await_2nd_reg, "decoder idle state not clean")
    `ASSERT_IMPL(a_pair_utf16, clk, rst_n, dec_push.push && dec_push.pair,
        !emit_utf32 && !err, "surrogate pair pushed in UTF-32 mode or on error")
    `ASSERT_IMPL(a_push_room, clk, rst_n, dec_push.push,
        out_free, "result pushed while output register busy")

endmodule

### hw/rtl/utu_out_buf.sv
// -----------------------------------------------------------------------------
// utu_out_buf
// Result register pair: presents the one or two result items pushed for a decoded byte.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module utu_out_buf import utu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dec_push_t dec_push,
    output logic      out_free,
    utu_out_if.source code_out
);

    result_t cur_reg;
    result_t nxt_reg;
    logic    valid_reg;
    logic    pend_reg;
    logic    pop;

    assign pop      = valid_reg && code_out.ready;
    assign out_free = !valid_reg || (pop && !pend_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (dec_push.push && out_free)
        begin
            valid_reg <= 1'b1;
            pend_reg  <= dec_push.pair;
        end
        else if (pop)
        begin
            valid_reg <= pend_reg;
            pend_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_push.push && out_free)
        begin
            cur_reg <= dec_push.res0;
            nxt_reg <= dec_push.res1;
        end
        else if (pop && pend_reg)
        begin
            cur_reg <= nxt_reg;
        end
    end

    assign code_out.valid       = valid_reg;
    assign code_out.code_value  = cur_reg.code_value;
    assign code_out.status      = cur_reg.status;
    assign code_out.last_of_run = cur_reg.last_of_run;
    assign code_out.text_done   = cur_reg.text_done;

    `ASSERT_IMPL(a_pend_valid, clk, rst_n, pend_reg, valid_reg,
        "second unit pending without a valid result")
    `ASSERT_NEXT(a_pair_load, clk, rst_n, dec_push.push && out_free && dec_push.pair,
        valid_reg && pend_reg, "pair not held after load")
    `ASSERT_NEXT(a_pair_shift, clk, rst_n, pop && pend_reg,
        valid_reg && !pend_reg, "second unit lost after first pop")

endmodule

### hw/rtl/utf8_to_utf16_transcoder.sv
// -----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream to UTF-16 code units or UTF-32 code points.
// -----------------------------------------------------------------------------
// Usage:
//   text_in  : one UTF-8 byte per item, end_of_text set on the final byte.
//   code_out : result items (code_value, status, last_of_run, text_done).
//   APB      : register 0 (byte address 0) bit 0 = emit_utf32; write only
//              while the block is idle. pready is always high.
// Path: input register, decode, then result register driving code_out. Bytes
//   that complete nothing and do not end the text give no item.
// Throughput: one byte per cycle while code_out is ready; a surrogate pair holds
//   the output register until both units pop, so the byte after it waits.
// Errors give a single item with status set and code_value zero; the decoder
//   returns to idle and carries on with the next byte.
// Reset: sequence state clears to idle, emit_utf32 clears to UTF-16 mode.
// Stall: while code_out is not ready the result register holds its item; one
//   more byte may sit in the input register, then text_in.ready drops.
// -----------------------------------------------------------------------------
module utf8_to_utf16_transcoder import utu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    utu_in_if.sink             text_in,
    utu_out_if.source          code_out
);

    logic      emit_utf32;
    logic      out_free;
    dec_push_t dec_push;

    utu_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .emit_utf32 (emit_utf32)
    );

    utu_decoder u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit_utf32 (emit_utf32),
        .text_in    (text_in),
        .out_free   (out_free),
        .dec_push   (dec_push)
    );

    utu_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .dec_push (dec_push),
        .out_free (out_free),
        .code_out (code_out)
    );

endmodule
